@@ rtl/drlm_pkg.sv @@
// Package for the dirty rectangle list block: sizes, rectangle type, codes
// and the union and touch helpers. No dependencies.
`default_nettype none
package drlm_pkg;

    localparam int LIST_CAPACITY = 256;
    localparam int RECHECK_LIMIT = 3;
    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int MW = $clog2(RECHECK_LIMIT + 1);

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } rect_t;

    localparam int RW = $bits(rect_t);

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_ROTATE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SEL_CUR  = 2'd0,
        SEL_NEXT = 2'd1,
        SEL_BOTH = 2'd2,
        SEL_BLIT = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        LIST_CUR  = 2'd0,
        LIST_NEXT = 2'd1,
        LIST_BLIT = 2'd2
    } list_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ADD_BEGIN,
        ST_COL_RD,
        ST_COL_ACC,
        ST_COL_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_MV,
        ST_APPEND,
        ST_ADD_END,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    function automatic rect_t rect_join(input rect_t a, input rect_t b);
        rect_t u;
        u.l = (a.l < b.l) ? a.l : b.l;
        u.t = (a.t < b.t) ? a.t : b.t;
        u.r = (a.r > b.r) ? a.r : b.r;
        u.b = (a.b > b.b) ? a.b : b.b;
        return u;
    endfunction

    // Entry e touches rectangle n once n is grown by one pixel on each side.
    // One guard bit keeps the growth from wrapping.
    function automatic logic rect_touch(input rect_t e, input rect_t n);
        logic signed [16:0] pl, pt, pr, pb, el, et, er, eb;
        logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
        pl = 17'(signed'(n.l)) - 17'sd1;
        pt = 17'(signed'(n.t)) - 17'sd1;
        pr = 17'(signed'(n.r)) + 17'sd1;
        pb = 17'(signed'(n.b)) + 17'sd1;
        el = 17'(signed'(e.l));
        et = 17'(signed'(e.t));
        er = 17'(signed'(e.r));
        eb = 17'(signed'(e.b));
        lo_x = (el > pl) ? el : pl;
        hi_x = (er < pr) ? er : pr;
        lo_y = (et > pt) ? et : pt;
        hi_y = (eb < pb) ? eb : pb;
        return (lo_x < hi_x) && (lo_y < hi_y);
    endfunction

endpackage
`default_nettype wire

@@ rtl/drlm_if.sv @@
// Handshake interfaces for the request and result words of the dirty
// rectangle list block. Depends on nothing.
`default_nettype none
interface drlm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         list_sel;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic [7:0]         entry_index;

    modport source (output valid, kind, list_sel, rect_left, rect_top, rect_right,
                    rect_bottom, entry_index, input ready);
    modport sink (input valid, kind, list_sel, rect_left, rect_top, rect_right,
                  rect_bottom, entry_index, output ready);
endinterface

interface drlm_out_if;
    logic               valid;
    logic               ready;
    logic [8:0]         list_count;
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic               entry_valid;
    logic               collapsed;

    modport source (output valid, list_count, out_left, out_top, out_right, out_bottom,
                    entry_valid, collapsed, input ready);
    modport sink (input valid, list_count, out_left, out_top, out_right, out_bottom,
                  entry_valid, collapsed, output ready);
endinterface
`default_nettype wire

@@ rtl/drlm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module drlm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/dirty_rect_list_merge.sv @@
// Top level of the dirty rectangle list block. Uses drlm_pkg, the
// interfaces in drlm_if.sv and the generic RAM drlm_ram.
`default_nettype none
// The block holds three lists of rectangles (current, next, blit), each in
// its own RAM with a registered read, plus a count register per list. One
// request word is handled at a time and yields one result word. An add
// walks the chosen list entry by entry: each entry is read and then tested,
// and a merged entry is followed by a step that pulls the last entry into
// its slot. An add to a full list instead collapses it into one entry. An
// add to current and next runs both lists one after the other. A rotate
// copies the next list into the current list entry by entry. The result
// word sits in an output register, so a new request is taken as soon as
// the sequencer is idle, even while the previous result still waits. No
// clearing pass is needed after reset: only entries below a list's count
// are ever read.
module dirty_rect_list_merge (
    input  wire logic clk,
    input  wire logic rst_n,
    drlm_in_if.sink   in_ch,
    drlm_out_if.source out_ch
);
    import drlm_pkg::*;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    sel_t              sel_reg, sel_next;
    rect_t             nr_reg, nr_next;
    logic [AW-1:0]     idx_reg, idx_next;
    list_t             list_reg, list_next;
    logic              both_reg, both_next;
    rect_t             acc_reg, acc_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [MW-1:0]     merges_reg, merges_next;
    logic [CW-1:0]     cur_cnt_reg, cur_cnt_next;
    logic [CW-1:0]     nxt_cnt_reg, nxt_cnt_next;
    logic [CW-1:0]     blt_cnt_reg, blt_cnt_next;
    logic [CW-1:0]     res_cnt_reg, res_cnt_next;
    rect_t             res_rect_reg, res_rect_next;
    logic              res_ev_reg, res_ev_next;
    logic              res_coll_reg, res_coll_next;
    logic              out_valid_reg, out_valid_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    rect_t             out_rect_reg, out_rect_next;
    logic              out_ev_reg, out_ev_next;
    logic              out_coll_reg, out_coll_next;

    // Shared RAM port controls; the list selectors steer them.
    logic              wr_en;
    logic [AW-1:0]     waddr;
    rect_t             wdata;
    logic [AW-1:0]     raddr;
    list_t             rd_list, wr_list;
    logic [RW-1:0]     rdata_cur, rdata_nxt, rdata_blt;
    rect_t             rdata;

    logic              rotating;
    logic              nr_empty;
    logic [CW-1:0]     list_cnt;
    logic [CW-1:0]     sel_cnt;
    logic [CW-1:0]     n_dec;
    logic              touch;

    assign rotating = (state_reg == ST_ROT_RD) || (state_reg == ST_ROT_WR);
    assign rd_list  = rotating ? LIST_NEXT : list_reg;
    assign wr_list  = rotating ? LIST_CUR : list_reg;

    drlm_ram #(.WIDTH(RW), .DEPTH(LIST_CAPACITY)) u_cur_ram (
        .clk   (clk),
        .we    (wr_en && (wr_list == LIST_CUR)),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_cur)
    );

    drlm_ram #(.WIDTH(RW), .DEPTH(LIST_CAPACITY)) u_nxt_ram (
        .clk   (clk),
        .we    (wr_en && (wr_list == LIST_NEXT)),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_nxt)
    );

    drlm_ram #(.WIDTH(RW), .DEPTH(LIST_CAPACITY)) u_blt_ram (
        .clk   (clk),
        .we    (wr_en && (wr_list == LIST_BLIT)),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_blt)
    );

    always_comb
    begin
        case (rd_list)
            LIST_NEXT: rdata = rect_t'(rdata_nxt);
            LIST_BLIT: rdata = rect_t'(rdata_blt);
            default:   rdata = rect_t'(rdata_cur);
        endcase
    end

    // Count of the list the sequencer is working on.
    always_comb
    begin
        case (list_reg)
            LIST_NEXT: list_cnt = nxt_cnt_reg;
            LIST_BLIT: list_cnt = blt_cnt_reg;
            default:   list_cnt = cur_cnt_reg;
        endcase
    end

    // Count reported for a request by its selector; both lists report next.
    always_comb
    begin
        case (sel_reg)
            SEL_CUR:  sel_cnt = cur_cnt_reg;
            SEL_BLIT: sel_cnt = blt_cnt_reg;
            default:  sel_cnt = nxt_cnt_reg;
        endcase
    end

    assign nr_empty = (nr_reg.r <= nr_reg.l) || (nr_reg.b <= nr_reg.t);
    assign n_dec    = n_reg - CW'(1);
    assign touch    = rect_touch(rdata, acc_reg);

    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        sel_next       = sel_reg;
        nr_next        = nr_reg;
        idx_next       = idx_reg;
        list_next      = list_reg;
        both_next      = both_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        merges_next    = merges_reg;
        cur_cnt_next   = cur_cnt_reg;
        nxt_cnt_next   = nxt_cnt_reg;
        blt_cnt_next   = blt_cnt_reg;
        res_cnt_next   = res_cnt_reg;
        res_rect_next  = res_rect_reg;
        res_ev_next    = res_ev_reg;
        res_coll_next  = res_coll_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_cnt_next   = out_cnt_reg;
        out_rect_next  = out_rect_reg;
        out_ev_next    = out_ev_reg;
        out_coll_next  = out_coll_reg;
        wr_en          = 1'b0;
        waddr          = i_reg[AW-1:0];
        wdata          = rdata;
        raddr          = i_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    kind_next  = kind_t'(in_ch.kind);
                    sel_next   = sel_t'(in_ch.list_sel);
                    nr_next.l  = in_ch.rect_left;
                    nr_next.t  = in_ch.rect_top;
                    nr_next.r  = in_ch.rect_right;
                    nr_next.b  = in_ch.rect_bottom;
                    idx_next   = AW'(in_ch.entry_index);
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                res_rect_next = '0;
                res_ev_next   = 1'b0;
                res_coll_next = 1'b0;
                res_cnt_next  = sel_cnt;
                case (sel_reg)
                    SEL_NEXT: list_next = LIST_NEXT;
                    SEL_BLIT: list_next = LIST_BLIT;
                    default:  list_next = LIST_CUR;
                endcase
                both_next = (sel_reg == SEL_BOTH);
                case (kind_reg)
                    KIND_ADD:
                    begin
                        state_next = nr_empty ? ST_DONE : ST_ADD_BEGIN;
                    end
                    KIND_ROTATE:
                    begin
                        n_next     = nxt_cnt_reg;
                        i_next     = '0;
                        state_next = ST_ROT_RD;
                    end
                    KIND_READ:
                    begin
                        // The selector for both lists reads current.
                        if (sel_reg == SEL_BOTH)
                        begin
                            res_cnt_next = cur_cnt_reg;
                        end
                        i_next = CW'(idx_reg);
                        raddr  = idx_reg;
                        if (CW'(idx_reg) < ((sel_reg == SEL_BOTH) ? cur_cnt_reg : sel_cnt))
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (sel_reg == SEL_CUR || sel_reg == SEL_BOTH)
                        begin
                            cur_cnt_next = '0;
                        end
                        if (sel_reg == SEL_NEXT || sel_reg == SEL_BOTH)
                        begin
                            nxt_cnt_next = '0;
                        end
                        if (sel_reg == SEL_BLIT)
                        begin
                            blt_cnt_next = '0;
                        end
                        res_cnt_next = '0;
                        state_next   = ST_DONE;
                    end
                endcase
            end

            ST_RD_WAIT:
            begin
                // The read address was issued from the requested index in the
                // start cycle.
                res_rect_next = rdata;
                res_ev_next   = 1'b1;
                state_next    = ST_DONE;
            end

            ST_ADD_BEGIN:
            begin
                n_next      = list_cnt;
                i_next      = '0;
                merges_next = '0;
                acc_next    = nr_reg;
                state_next  = (list_cnt == CW'(LIST_CAPACITY)) ? ST_COL_RD : ST_SCAN_RD;
            end

            ST_COL_RD:
            begin
                state_next = ST_COL_ACC;
            end

            ST_COL_ACC:
            begin
                acc_next = rect_join(acc_reg, rdata);
                if (i_reg == CW'(LIST_CAPACITY - 1))
                begin
                    state_next = ST_COL_WR;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_COL_RD;
                end
            end

            ST_COL_WR:
            begin
                wr_en         = 1'b1;
                waddr         = '0;
                wdata         = acc_reg;
                n_next        = CW'(1);
                res_coll_next = 1'b1;
                state_next    = ST_ADD_END;
            end

            ST_SCAN_RD:
            begin
                state_next = (i_reg < n_reg) ? ST_SCAN_CHK : ST_APPEND;
            end

            ST_SCAN_CHK:
            begin
                if (touch)
                begin
                    // Merge, then fetch the last entry to fill this slot.
                    acc_next = rect_join(acc_reg, rdata);
                    n_next   = n_dec;
                    raddr    = n_dec[AW-1:0];
                    if (merges_reg != MW'(RECHECK_LIMIT))
                    begin
                        merges_next = merges_reg + MW'(1);
                    end
                    state_next = ST_SCAN_MV;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_MV:
            begin
                wr_en = 1'b1;
                wdata = rdata;
                // The slot is checked again only for the first few merges.
                if (merges_reg >= MW'(RECHECK_LIMIT))
                begin
                    i_next = i_reg + CW'(1);
                end
                state_next = ST_SCAN_RD;
            end

            ST_APPEND:
            begin
                wr_en      = 1'b1;
                waddr      = n_reg[AW-1:0];
                wdata      = acc_reg;
                n_next     = n_reg + CW'(1);
                state_next = ST_ADD_END;
            end

            ST_ADD_END:
            begin
                case (list_reg)
                    LIST_NEXT: nxt_cnt_next = n_reg;
                    LIST_BLIT: blt_cnt_next = n_reg;
                    default:   cur_cnt_next = n_reg;
                endcase
                res_cnt_next = n_reg;
                if (both_reg)
                begin
                    both_next  = 1'b0;
                    list_next  = LIST_NEXT;
                    state_next = ST_ADD_BEGIN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_ROT_RD:
            begin
                if (i_reg < n_reg)
                begin
                    state_next = ST_ROT_WR;
                end
                else
                begin
                    cur_cnt_next = n_reg;
                    nxt_cnt_next = '0;
                    res_cnt_next = n_reg;
                    state_next   = ST_DONE;
                end
            end

            ST_ROT_WR:
            begin
                wr_en      = 1'b1;
                wdata      = rdata;
                i_next     = i_reg + CW'(1);
                state_next = ST_ROT_RD;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = res_cnt_reg;
                    out_rect_next  = res_rect_reg;
                    out_ev_next    = res_ev_reg;
                    out_coll_next  = res_coll_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_cnt_reg   <= '0;
            nxt_cnt_reg   <= '0;
            blt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            both_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_cnt_reg   <= cur_cnt_next;
            nxt_cnt_reg   <= nxt_cnt_next;
            blt_cnt_reg   <= blt_cnt_next;
            out_valid_reg <= out_valid_next;
            both_reg      <= both_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sel_reg      <= sel_next;
        nr_reg       <= nr_next;
        idx_reg      <= idx_next;
        list_reg     <= list_next;
        acc_reg      <= acc_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        merges_reg   <= merges_next;
        res_cnt_reg  <= res_cnt_next;
        res_rect_reg <= res_rect_next;
        res_ev_reg   <= res_ev_next;
        res_coll_reg <= res_coll_next;
        out_cnt_reg  <= out_cnt_next;
        out_rect_reg <= out_rect_next;
        out_ev_reg   <= out_ev_next;
        out_coll_reg <= out_coll_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.list_count  = 9'(out_cnt_reg);
    assign out_ch.out_left    = out_rect_reg.l;
    assign out_ch.out_top     = out_rect_reg.t;
    assign out_ch.out_right   = out_rect_reg.r;
    assign out_ch.out_bottom  = out_rect_reg.b;
    assign out_ch.entry_valid = out_ev_reg;
    assign out_ch.collapsed   = out_coll_reg;
endmodule
`default_nettype wire
